>>> design/pcm2dac_pkg.sv
package pcm2dac_pkg;

    // frame layout
    localparam int FRAME_CH      = 6;
    localparam int SAMPLE_W      = 16;
    localparam int CHAN_W        = 3;
    localparam int ADDR_W        = 3;
    localparam int BYTE_W        = 8;
    localparam int MAP_W         = FRAME_CH * ADDR_W;
    localparam int DEF_MAX_CH    = 6;

    // configuration register indexes
    localparam logic CFG_IDX_CHANNELS = 1'b0;
    localparam logic CFG_IDX_ADDR_MAP = 1'b1;

    // configuration reset values
    localparam logic [CHAN_W-1:0] CHANNELS_RESET = 3'd6;
    localparam logic [MAP_W-1:0]  MAP_RESET      = 18'd252104;

    // one pending dac command as it travels down the cell row
    typedef struct packed {
        logic              pend;
        logic [CHAN_W-1:0] chan;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
    } t_cmd;

    // first byte: address at bits 6..4 ORed with the sign-extended sample >> 11
    function automatic logic [BYTE_W-1:0] cmd_high(input logic [SAMPLE_W-1:0] s,
                                                   input logic [ADDR_W-1:0] a);
        cmd_high = {s[15], a[2] | s[15], a[1] | s[15], a[0] | s[15], s[14:11]};
    endfunction

    // second byte: sample >> 3, low eight bits
    function automatic logic [BYTE_W-1:0] cmd_low(input logic [SAMPLE_W-1:0] s);
        cmd_low = s[10:3];
    endfunction

endpackage

>>> design/pcm2dac_cell.sv
module pcm2dac_cell
    import pcm2dac_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_shift,
    input  logic                i_enable,
    input  logic [CHAN_W-1:0]   i_chan,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [ADDR_W-1:0]   i_addr,
    input  t_cmd                i_next,
    output t_cmd                o_cmd
);

    logic [SAMPLE_W-1:0] r_prev;
    t_cmd                r_cmd;
    logic                w_change;

    // channel in use and sample differs from the one last sent
    assign w_change = i_enable && (i_sample != r_prev);

    // load a fresh command on a new frame, otherwise take the neighbor's when the row shifts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_cmd  <= '0;
        end else if (i_load) begin
            r_cmd.pend <= w_change;
            r_cmd.chan <= i_chan;
            r_cmd.hi   <= cmd_high(i_sample, i_addr);
            r_cmd.lo   <= cmd_low(i_sample);
            if (w_change) begin
                r_prev <= i_sample;
            end
        end else if (i_shift) begin
            r_cmd <= i_next;
        end
    end

    assign o_cmd = r_cmd;

endmodule

>>> design/pcm_frame_to_dac_updates.sv
// Frame to dac command converter.
// Slave stream: one word per audio frame, six signed 16-bit samples in
// i_s_tdata (channel zero lowest). Master stream: one word per changed
// sample, o_m_tdata = {5'b0, command_low, command_high, source_channel},
// o_m_tlast marks the final command of a frame. A frame with no changed
// channel in use produces no word.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0: channels in use, 1: 18-bit channel address map); write only when idle.
// Each channel has one cell holding its last sent sample. On a frame the
// cells compare and latch a pending command, then the row shifts toward cell
// zero one cell per cycle unless held. Each command passes from cell zero
// into the output register, and i_s_tready stays low until the command of
// the highest changed channel has left the row; a frame with no changed
// channel in use leaves i_s_tready high. The output register lets the next
// frame be taken while the last command still waits. When the receiver
// stalls and cell zero holds a pending command, the row holds until the
// output register frees. Reset clears all stored samples to zero and
// restores six channels and the default map.
module pcm_frame_to_dac_updates
    import pcm2dac_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sample_ch0 .. sample_ch5, 16 bits each
    input  logic [FRAME_CH*SAMPLE_W-1:0] i_s_tdata,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // source_channel[2:0], command_high[10:3], command_low[18:11], zero pad
    output logic [23:0]                  o_m_tdata,
    output logic                         o_m_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [MAP_W-1:0]             i_cfg_data
);

    localparam int NCELL = (MAX_CHANNELS < FRAME_CH) ? MAX_CHANNELS : FRAME_CH;

    logic [CHAN_W-1:0] r_channels;
    logic [MAP_W-1:0]  r_map;
    t_cmd              w_cmd [NCELL+1];
    logic [NCELL-1:0]  w_pend;
    logic              w_load;
    logic              w_out_free;
    logic              w_shift;
    logic              w_move;
    logic              w_rest_pend;
    logic              r_out_valid;
    t_cmd              r_out;
    logic              r_out_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels <= CHANNELS_RESET;
            r_map      <= MAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_CHANNELS: r_channels <= i_cfg_data[CHAN_W-1:0];
                CFG_IDX_ADDR_MAP: r_map      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake and row control
    assign o_s_tready  = ~|w_pend;
    assign w_load      = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_move      = w_cmd[0].pend && w_out_free;
    assign w_shift     = !w_cmd[0].pend || w_out_free;
    assign w_rest_pend = |(w_pend & ~NCELL'(1));
    assign w_cmd[NCELL] = '0;

    // row of channel cells
    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        pcm2dac_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (w_load),
            .i_shift  (w_shift),
            .i_enable (CHAN_W'(c) < r_channels),
            .i_chan   (CHAN_W'(c)),
            .i_sample (i_s_tdata[c*SAMPLE_W +: SAMPLE_W]),
            .i_addr   (r_map[c*ADDR_W +: ADDR_W]),
            .i_next   (w_cmd[c+1]),
            .o_cmd    (w_cmd[c])
        );
        assign w_pend[c] = w_cmd[c].pend;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out      <= w_cmd[0];
            r_out_last <= !w_rest_pend;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {5'b0, r_out.lo, r_out.hi, r_out.chan};

    // a word that is not the last of its frame has more commands behind it
    a_more_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (|w_pend))
        else $error("non-last word with no pending command behind it");

    // emitted channel always has a cell
    a_chan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (int'(o_m_tdata[CHAN_W-1:0]) < NCELL))
        else $error("source channel out of range");

    // without a new frame the pending count never grows
    a_pend_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> ($countones(w_pend) <= $past($countones(w_pend))))
        else $error("pending commands appeared without a frame");

    // a word moves out only when the head cell holds one
    a_move_from_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_cmd[0].pend && !r_out_valid) |=> !r_out_valid || $past(w_load))
        else $error("output word without pending head command");

endmodule

>>> tb/dac_command_checker.sv
// watches both streams and the register port, predicts dac commands per frame
module dac_command_checker
    import pcm2dac_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // sample_ch0 .. sample_ch5, 16 bits each
    input  logic [FRAME_CH*SAMPLE_W-1:0] i_s_tdata,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    // source_channel[2:0], command_high[10:3], command_low[18:11], zero pad
    input  logic [23:0]                  i_m_tdata,
    input  logic                         i_m_tlast,
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [MAP_W-1:0]             i_cfg_data,
    output int                           o_pending,
    output int                           o_errors
);

    localparam int ADDR_SHIFT = 4;
    localparam int HIGH_SHIFT = 11;
    localparam int LOW_SHIFT  = 3;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        logic              frame_end;
    } t_dac_cmd;

    // own copy of the per-channel sample store and the registers
    logic [SAMPLE_W-1:0] sent_sample [FRAME_CH];
    logic [CHAN_W-1:0]   chan_count;
    logic [MAP_W-1:0]    addr_map;
    t_dac_cmd            expected_cmds [$];
    t_dac_cmd            want;
    int                  mismatches = 0;

    assign o_errors = mismatches;

    task automatic flag_mismatch(input string what, input int got, input int exp_val);
        mismatches++;
        $display("dac checker: %s got %0h expected %0h at %0t", what, got, exp_val, $realtime);
    endtask

    // one command per changed sample among the channels in use, last one marked
    task automatic predict_commands(input logic [FRAME_CH*SAMPLE_W-1:0] frame);
        int                         limit;
        logic signed [SAMPLE_W-1:0] smp;
        logic [SAMPLE_W-1:0]        shifted;
        logic [ADDR_W-1:0]          addr;
        t_dac_cmd                   cmd;
        t_dac_cmd                   held;
        logic                       have_held;
        limit = chan_count;
        if (limit > MAX_CHANNELS) limit = MAX_CHANNELS;
        if (limit > FRAME_CH) limit = FRAME_CH;
        have_held = 1'b0;
        held = '0;
        for (int c = 0; c < limit; c++) begin
            smp = frame[c*SAMPLE_W +: SAMPLE_W];
            if (smp == sent_sample[c]) continue;
            addr = addr_map[c*ADDR_W +: ADDR_W];
            // arithmetic shift: a negative sample floods the address bits
            shifted = smp >>> HIGH_SHIFT;
            cmd.chan = CHAN_W'(c);
            cmd.hi = (BYTE_W'(addr) << ADDR_SHIFT) | shifted[BYTE_W-1:0];
            cmd.lo = smp[LOW_SHIFT +: BYTE_W];
            cmd.frame_end = 1'b0;
            sent_sample[c] = smp;
            if (have_held) expected_cmds.push_back(held);
            held = cmd;
            have_held = 1'b1;
        end
        if (have_held) begin
            held.frame_end = 1'b1;
            expected_cmds.push_back(held);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < FRAME_CH; c++) sent_sample[c] = '0;
            chan_count = CHANNELS_RESET;
            addr_map = MAP_RESET;
            expected_cmds.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_CHANNELS)
                    chan_count = i_cfg_data[CHAN_W-1:0];
                else if (i_cfg_idx == CFG_IDX_ADDR_MAP)
                    addr_map = i_cfg_data;
            end
            // accepted frame
            if (i_s_tvalid && i_s_tready) predict_commands(i_s_tdata);
            // accepted command word
            if (i_m_tvalid && i_m_tready) begin
                if (expected_cmds.size() == 0) begin
                    flag_mismatch("word with nothing expected", i_m_tdata, 0);
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_m_tdata[2:0] != want.chan)
                        flag_mismatch("source channel", i_m_tdata[2:0], want.chan);
                    if (i_m_tdata[10:3] != want.hi)
                        flag_mismatch("command high", i_m_tdata[10:3], want.hi);
                    if (i_m_tdata[18:11] != want.lo)
                        flag_mismatch("command low", i_m_tdata[18:11], want.lo);
                    if (i_m_tlast != want.frame_end)
                        flag_mismatch("last of frame", i_m_tlast, want.frame_end);
                    if (i_m_tdata[23:19] != '0)
                        flag_mismatch("pad bits", i_m_tdata[23:19], 0);
                end
            end
        end
        o_pending = expected_cmds.size();
    end

endmodule

>>> tb/testbench.sv
module testbench;
    import pcm2dac_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int SETTLE      = DEF_MAX_CH + 8;
    localparam int PHASES      = 9;
    localparam int PHASE_WORDS = 60;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} t_rx_mode;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic [FRAME_CH*SAMPLE_W-1:0] s_tdata = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [23:0]                  m_tdata;
    logic                         m_tlast;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic                         cfg_we = 1'b0;
    logic                         cfg_idx = CFG_IDX_CHANNELS;
    logic [MAP_W-1:0]             cfg_data = '0;
    int                           pending;
    int                           errors;
    int                           cycle_count = 0;
    int                           burst_left = 0;
    t_rx_mode                     rx_mode = RX_OPEN;
    int                           rx_left = 0;
    int                           rx_stall = 0;
    logic [FRAME_CH*SAMPLE_W-1:0] last_frame = '0;

    always #5 clk = ~clk;

    pcm_frame_to_dac_updates #(
        .MAX_CHANNELS(DEF_MAX_CH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dac_command_checker #(
        .MAX_CHANNELS(DEF_MAX_CH)
    ) u_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tlast  (m_tlast),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // run watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver back-pressure, switching between open, coin-flip, sparse and long stalls
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN: begin
                m_tready <= 1'b1;
            end
            RX_COIN: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (rx_stall > 0) begin
                    m_tready <= 1'b0;
                    rx_stall--;
                end else begin
                    m_tready <= 1'b1;
                    rx_stall = $urandom_range(1, 24);
                end
            end
        endcase
    end

    task automatic write_reg(input logic idx, input logic [MAP_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // present one frame word, with a random gap before each new burst
    task automatic send_frame(input logic [FRAME_CH*SAMPLE_W-1:0] frame);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= frame;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        last_frame = frame;
    endtask

    // wait until every expected command has come and the block has settled
    task automatic drain_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial begin
        logic [FRAME_CH*SAMPLE_W-1:0] dir_list [10];
        logic [FRAME_CH*SAMPLE_W-1:0] frame;
        logic [SAMPLE_W-1:0]          smp;
        int                           phase_count [PHASES];
        logic [MAP_W-1:0]             phase_map [PHASES];
        int                           words;

        // samples listed ch5 down to ch0
        dir_list[0] = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        dir_list[1] = {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF};
        dir_list[2] = dir_list[1];
        dir_list[3] = {16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h8000, 16'h0000};
        dir_list[4] = {16'hAAAA, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h8000, 16'h0000};
        dir_list[5] = {16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000};
        dir_list[6] = {16'h8001, 16'h07F8, 16'hF800, 16'h0007, 16'h0800, 16'h0008};
        dir_list[7] = {16'h8001, 16'h07F8, 16'hF800, 16'h0000, 16'h0800, 16'h0008};
        dir_list[8] = {16'hFFF8, 16'h8000, 16'h7FFF, 16'h0400, 16'hFC00, 16'h8000};
        dir_list[9] = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};

        // channel count and address map per phase, extremes first
        phase_count = '{7, 0, 1, 3, 6, 5, 2, 4, 6};
        phase_map[0] = '1;
        phase_map[1] = '1;
        phase_map[2] = '0;
        for (int p = 3; p < PHASES - 1; p++) phase_map[p] = MAP_W'($urandom);
        phase_map[PHASES-1] = MAP_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frames on the reset configuration
        for (int i = 0; i < 10; i++) send_frame(dir_list[i]);
        drain_block();

        for (int p = 0; p < PHASES; p++) begin
            // upper data bits of the count write carry noise
            write_reg(CFG_IDX_CHANNELS, {MAP_W'($urandom)} & ~MAP_W'(7) | MAP_W'(phase_count[p]));
            write_reg(CFG_IDX_ADDR_MAP, phase_map[p]);
            words = (phase_count[p] == 0) ? 12 : PHASE_WORDS;
            for (int n = 0; n < words; n++) begin
                frame = last_frame;
                // whole frame repeated now and then, else per-channel keep/extreme/random
                if ($urandom_range(0, 15) != 0) begin
                    for (int c = 0; c < FRAME_CH; c++) begin
                        smp = frame[c*SAMPLE_W +: SAMPLE_W];
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: ;
                            4: begin
                                case ($urandom_range(0, 3))
                                    0: smp = 16'h0000;
                                    1: smp = 16'h7FFF;
                                    2: smp = 16'h8000;
                                    default: smp = 16'hFFFF;
                                endcase
                            end
                            default: smp = SAMPLE_W'($urandom);
                        endcase
                        frame[c*SAMPLE_W +: SAMPLE_W] = smp;
                    end
                end
                send_frame(frame);
            end
            drain_block();
        end

        repeat (2 * SETTLE) @(posedge clk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/pcm2dac_pkg.sv
design/pcm2dac_cell.sv
design/pcm_frame_to_dac_updates.sv
tb/dac_command_checker.sv
tb/testbench.sv
